// ===== rtl/core/nau_pkg.sv =====
// Shared types, constants and tables for the neural activation unit.
package nau_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = 17;
    localparam int ARG_W      = 21;
    localparam int EXP_W      = 17;
    localparam int NUM_W      = 34;
    localparam int DEN_W      = 18;
    localparam int QUO_W      = 17;
    localparam int Y_W        = 18;
    localparam int MODE_W     = 3;
    localparam int SLOPE_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [MODE_W-1:0] MODE_RELU    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LEAKY   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SIGMOID = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TANH    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_GELU    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_BYPASS  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE = 2'd1;

    localparam logic [SLOPE_W-1:0] SLOPE_RESET = 16'd655;

    // log2(e) in Q.16, ln(2) in Q.16, 0.044715 and sqrt(2/pi) in Q.24
    localparam logic [16:0] LOG2E_Q16   = 17'd94548;
    localparam logic [15:0] LN2_Q16     = 16'd45426;
    localparam logic [19:0] GELU_C_Q24  = 20'd750193;
    localparam logic [23:0] SQRT2PI_Q24 = 24'd13386282;

    typedef struct packed {
        logic [MODE_W-1:0]          mode;
        logic signed [SAMPLE_W-1:0] x;
        logic [MAG_W-1:0]           mag;
        logic signed [Y_W-1:0]      simple_y;
    } nau_side_t;

    // 2^(-k/16) in Q.16
    function automatic logic [16:0] pow2_frac(input logic [3:0] k);
        logic [16:0] v;
        case (k)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd62757;
            4'd2:    v = 17'd60097;
            4'd3:    v = 17'd57549;
            4'd4:    v = 17'd55109;
            4'd5:    v = 17'd52773;
            4'd6:    v = 17'd50535;
            4'd7:    v = 17'd48393;
            4'd8:    v = 17'd46341;
            4'd9:    v = 17'd44376;
            4'd10:   v = 17'd42495;
            4'd11:   v = 17'd40693;
            4'd12:   v = 17'd38968;
            4'd13:   v = 17'd37316;
            4'd14:   v = 17'd35734;
            default: v = 17'd34219;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/nau_sample_if.sv =====
// Input stream channel carrying one signed sample per beat.
interface nau_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [nau_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// ===== rtl/core/nau_result_if.sv =====
// Output stream channel carrying one activation result per beat.
interface nau_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [nau_pkg::SAMPLE_W-1:0] activated;

    modport source (output valid, output activated, input ready);
    modport sink   (input valid, input activated, output ready);
endinterface

// ===== rtl/core/nau_arg.sv =====
// Front pipeline: magnitude, leaky/relu result, GELU polynomial and exp argument.
module nau_arg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                in_vld,
    input  logic signed [nau_pkg::SAMPLE_W-1:0] in_x,
    input  logic [nau_pkg::MODE_W-1:0]          in_mode,
    input  logic [nau_pkg::SLOPE_W-1:0]         in_slope,
    output logic                                out_vld,
    output logic [nau_pkg::ARG_W-1:0]           out_t,
    output nau_pkg::nau_side_t                  out_side
);

    logic [6:0] vld_reg;

    nau_pkg::nau_side_t s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg, s7_reg;
    logic [nau_pkg::SLOPE_W-1:0] slope1_reg;
    logic [30:0] sq2_reg;
    logic [31:0] lp2_reg;
    logic [45:0] cube3_reg;
    logic [47:0] cp4_reg;
    logic [23:0] inner5_reg;
    logic [47:0] cmp6_reg;
    logic [nau_pkg::ARG_W-1:0] t7_reg;

    logic [nau_pkg::MAG_W-1:0] mag_c;
    logic [33:0] sq_c;
    logic [32:0] lp_c;
    logic [47:0] cube_c;
    logic [46:0] cube_rnd_c;
    logic [28:0] c3_c;
    logic [48:0] cp_c;
    logic [47:0] cp_rnd_c;
    logic [23:0] inner_c;
    logic [47:0] cmp_c;
    logic [47:0] cm_rnd_c;
    logic [23:0] cm_c;
    logic [20:0] z_c;
    logic [19:0] zc_c;
    logic [19:0] cmc_c;
    logic [nau_pkg::ARG_W-1:0] t_c;
    logic [31:0] lr_sum_c;
    logic [15:0] lr_c;
    logic signed [nau_pkg::Y_W-1:0] x_ext_c;
    logic signed [nau_pkg::Y_W-1:0] simple_c;
    nau_pkg::nau_side_t s3_side_c;

    // Magnitude of the sample
    assign mag_c = in_x[15] ? (~{in_x[15], in_x} + 17'd1) : {1'b0, in_x};

    // Square, cube and leak product
    assign sq_c   = s1_reg.mag * s1_reg.mag;
    assign lp_c   = s1_reg.mag * slope1_reg;
    assign cube_c = sq2_reg * s2_reg.mag;

    // Relu and leaky relu results
    assign lr_sum_c = lp2_reg + 32'd32768;
    assign lr_c     = lr_sum_c[31:16];
    assign x_ext_c  = {{2{s2_reg.x[15]}}, s2_reg.x};

    always_comb
    begin
        case (s2_reg.mode)
            nau_pkg::MODE_RELU:  simple_c = s2_reg.x[15] ? '0 : x_ext_c;
            nau_pkg::MODE_LEAKY: simple_c = s2_reg.x[15] ? (18'sd0 - $signed({2'b0, lr_c}))
                                                         : x_ext_c;
            default:             simple_c = x_ext_c;
        endcase
    end

    // Attach the simple result to the side data
    always_comb
    begin
        s3_side_c          = s2_reg;
        s3_side_c.simple_y = simple_c;
    end

    // GELU inner polynomial
    assign cube_rnd_c = {1'b0, cube3_reg} + 47'd65536;
    assign c3_c       = cube_rnd_c[45:17];
    assign cp_c       = c3_c * nau_pkg::GELU_C_Q24;
    assign cp_rnd_c   = cp4_reg + 48'd8388608;
    assign inner_c    = {3'b0, s4_reg.mag[15:0], 5'b0} + cp_rnd_c[47:24];
    assign cmp_c      = inner5_reg * nau_pkg::SQRT2PI_Q24;
    assign cm_rnd_c   = cmp6_reg + 48'd8388608;
    assign cm_c       = cm_rnd_c[47:24];

    // Exp argument per mode, clamped at 8.0 for tanh and GELU
    assign z_c   = {s6_reg.mag[15:0], 5'b0};
    assign zc_c  = (z_c > 21'd524288) ? 20'd524288 : z_c[19:0];
    assign cmc_c = (cm_c > 24'd524288) ? 20'd524288 : cm_c[19:0];

    always_comb
    begin
        case (s6_reg.mode)
            nau_pkg::MODE_SIGMOID: t_c = z_c;
            nau_pkg::MODE_TANH:    t_c = {zc_c, 1'b0};
            nau_pkg::MODE_GELU:    t_c = {cmc_c, 1'b0};
            default:               t_c = '0;
        endcase
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[5:0], in_vld};
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg.mode     <= in_mode;
            s1_reg.x        <= in_x;
            s1_reg.mag      <= mag_c;
            s1_reg.simple_y <= '0;
            slope1_reg      <= in_slope;
            s2_reg          <= s1_reg;
            sq2_reg         <= sq_c[30:0];
            lp2_reg         <= lp_c[31:0];
            s3_reg          <= s3_side_c;
            cube3_reg       <= cube_c[45:0];
            s4_reg          <= s3_reg;
            cp4_reg         <= cp_c[47:0];
            s5_reg          <= s4_reg;
            inner5_reg      <= inner_c;
            s6_reg          <= s5_reg;
            cmp6_reg        <= cmp_c;
            s7_reg          <= s6_reg;
            t7_reg          <= t_c;
        end
    end

    assign out_vld  = vld_reg[6];
    assign out_t    = t7_reg;
    assign out_side = s7_reg;

endmodule

// ===== rtl/core/nau_exp.sv =====
// Pipelined exp(-t) in Q1.16 from a Q.16 argument.
module nau_exp
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       in_vld,
    input  logic [nau_pkg::ARG_W-1:0]  in_t,
    input  nau_pkg::nau_side_t         in_side,
    output logic                       out_vld,
    output logic [nau_pkg::EXP_W-1:0]  out_e,
    output nau_pkg::nau_side_t         out_side
);

    logic [5:0] vld_reg;
    nau_pkg::nau_side_t s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg;

    logic [37:0] up1_reg;
    logic [4:0]  n2_reg, n3_reg, n4_reg, n5_reg;
    logic [3:0]  k2_reg, k3_reg;
    logic [27:0] ar2_reg;
    logic [11:0] a3_reg;
    logic [23:0] aa3_reg;
    logic [33:0] tp4_reg;
    logic [16:0] m5_reg;
    logic [16:0] e6_reg;

    logic [37:0] up_c;
    logic [37:0] u_sum_c;
    logic [20:0] u_c;
    logic [27:0] ar_c;
    logic [27:0] ar_sum_c;
    logic [11:0] a_c;
    logic [23:0] aa_c;
    logic [24:0] aa_sum_c;
    logic [16:0] p_c;
    logic [33:0] tp_c;
    logic [34:0] tp_sum_c;
    logic [17:0] rnd_c;
    logic [17:0] sh_sum_c;
    logic [17:0] sh_c;
    logic [16:0] e_c;

    // Scale by log2(e) and split into integer, table index and remainder
    assign up_c     = in_t * nau_pkg::LOG2E_Q16;
    assign u_sum_c  = up1_reg + 38'd32768;
    assign u_c      = u_sum_c[36:16];
    assign ar_c     = u_c[11:0] * nau_pkg::LN2_Q16;

    // Second-order polynomial for the remainder
    assign ar_sum_c = ar2_reg + 28'd32768;
    assign a_c      = ar_sum_c[27:16];
    assign aa_c     = a_c * a_c;
    assign aa_sum_c = {1'b0, aa3_reg} + 25'd65536;
    assign p_c      = 17'd65536 - {5'b0, a3_reg} + {9'b0, aa_sum_c[24:17]};
    assign tp_c     = nau_pkg::pow2_frac(k3_reg) * p_c;

    // Scale by the table value, then shift by the integer part
    assign tp_sum_c = {1'b0, tp4_reg} + 35'd32768;
    assign rnd_c    = (n5_reg == 5'd0) ? 18'd0 : (18'd1 << (n5_reg - 5'd1));
    assign sh_sum_c = {1'b0, m5_reg} + rnd_c;
    assign sh_c     = sh_sum_c >> n5_reg;
    assign e_c      = (n5_reg >= 5'd18) ? 17'd0 : sh_c[16:0];

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[4:0], in_vld};
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg  <= in_side;
            up1_reg <= up_c;
            s2_reg  <= s1_reg;
            n2_reg  <= u_c[20:16];
            k2_reg  <= u_c[15:12];
            ar2_reg <= ar_c;
            s3_reg  <= s2_reg;
            n3_reg  <= n2_reg;
            k3_reg  <= k2_reg;
            a3_reg  <= a_c;
            aa3_reg <= aa_c;
            s4_reg  <= s3_reg;
            n4_reg  <= n3_reg;
            tp4_reg <= tp_c;
            s5_reg  <= s4_reg;
            n5_reg  <= n4_reg;
            m5_reg  <= tp_sum_c[32:16];
            s6_reg  <= s5_reg;
            e6_reg  <= e_c;
        end
    end

    assign out_vld  = vld_reg[5];
    assign out_e    = e6_reg;
    assign out_side = s6_reg;

endmodule

// ===== rtl/core/nau_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module nau_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       in_vld,
    input  logic [nau_pkg::NUM_W-1:0]  in_num,
    input  logic [nau_pkg::DEN_W-1:0]  in_den,
    input  nau_pkg::nau_side_t         in_side,
    output logic                       out_vld,
    output logic [nau_pkg::QUO_W-1:0]  out_q,
    output nau_pkg::nau_side_t         out_side
);

    localparam int STAGES = nau_pkg::QUO_W;

    logic [STAGES-1:0] vld_reg;
    logic [nau_pkg::NUM_W-1:0] rem_reg [STAGES];
    logic [nau_pkg::DEN_W-1:0] den_reg [STAGES];
    logic [nau_pkg::QUO_W-1:0] q_reg   [STAGES];
    nau_pkg::nau_side_t        side_reg [STAGES];

    logic [nau_pkg::NUM_W-1:0] rem_c  [STAGES+1];
    logic [nau_pkg::DEN_W-1:0] den_c  [STAGES+1];
    logic [nau_pkg::QUO_W-1:0] q_c    [STAGES+1];
    nau_pkg::nau_side_t        side_c [STAGES+1];

    assign rem_c[0]  = in_num;
    assign den_c[0]  = in_den;
    assign q_c[0]    = '0;
    assign side_c[0] = in_side;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_vld};
        end
    end

    for (genvar j = 0; j < STAGES; j++)
    begin : g_stage
        localparam int BIT = STAGES - 1 - j;
        localparam logic [nau_pkg::QUO_W-1:0] BIT_MASK =
            {{(nau_pkg::QUO_W - 1){1'b0}}, 1'b1} << BIT;

        logic [nau_pkg::NUM_W:0] dsh_c;
        logic [nau_pkg::NUM_W:0] trial_c;

        // Try subtracting the shifted divisor
        assign dsh_c   = {{(nau_pkg::NUM_W + 1 - nau_pkg::DEN_W){1'b0}}, den_c[j]} << BIT;
        assign trial_c = {1'b0, rem_c[j]} - dsh_c;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                den_reg[j]  <= den_c[j];
                side_reg[j] <= side_c[j];
                if (!trial_c[nau_pkg::NUM_W])
                begin
                    rem_reg[j] <= trial_c[nau_pkg::NUM_W-1:0];
                    q_reg[j]   <= q_c[j] | BIT_MASK;
                end
                else
                begin
                    rem_reg[j] <= rem_c[j];
                    q_reg[j]   <= q_c[j];
                end
            end
        end

        assign rem_c[j+1]  = rem_reg[j];
        assign den_c[j+1]  = den_reg[j];
        assign q_c[j+1]    = q_reg[j];
        assign side_c[j+1] = side_reg[j];
    end

    assign out_vld  = vld_reg[STAGES-1];
    assign out_q    = q_c[STAGES];
    assign out_side = side_c[STAGES];

endmodule

// ===== rtl/core/neural_activation_unit.sv =====
// Top level of the element-wise activation unit.
//
// Usage: samples (signed Q4.11) arrive as beats on in_ch; one result per
// sample leaves on out_ch, in order, as signed Q4.11, rounded and saturated.
// The mode and leak_slope registers are written through cfg_we/cfg_idx/
// cfg_data (index 0 mode, index 1 leak slope); the user must write them only
// while no beats are in flight; the block does not enforce this. There are
// 7 front stages (magnitude, cube, GELU polynomial), 6 exp stages, one
// divider setup stage, 17 divider stages (one quotient bit per stage) and
// 2 output stages; one beat per cycle unless stalled; one path for all modes.
// Stall: the whole pipeline advances together whenever the output register
// is empty or being taken; in_ch.ready follows that, so a stalled receiver
// holds every stage and nothing is lost or repeated.
// Reset: clears all valid bits, mode to relu and leak slope to 655.
module neural_activation_unit
#(
    parameter int DATA_WIDTH = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    nau_sample_if.sink                         in_ch,
    nau_result_if.source                       out_ch,
    input  logic                               cfg_we,
    input  logic [nau_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [nau_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam logic signed [32:0] SAT_HI = (33'sd1 <<< (DATA_WIDTH - 1)) - 33'sd1;
    localparam logic signed [32:0] SAT_LO = -SAT_HI - 33'sd1;

    logic [nau_pkg::MODE_W-1:0]  mode_reg;
    logic [nau_pkg::SLOPE_W-1:0] slope_reg;
    logic adv;

    logic                        arg_vld;
    logic [nau_pkg::ARG_W-1:0]   arg_t;
    nau_pkg::nau_side_t          arg_side;
    logic                        exp_vld;
    logic [nau_pkg::EXP_W-1:0]   exp_e;
    nau_pkg::nau_side_t          exp_side;
    logic                        div_vld;
    logic [nau_pkg::QUO_W-1:0]   div_q;
    nau_pkg::nau_side_t          div_side;

    logic                        prep_vld_reg;
    logic [nau_pkg::NUM_W-1:0]   prep_num_reg;
    logic [nau_pkg::DEN_W-1:0]   prep_den_reg;
    nau_pkg::nau_side_t          prep_side_reg;

    logic                        p1_vld_reg;
    nau_pkg::nau_side_t          p1_side_reg;
    logic [34:0]                 p1_gp_reg;
    logic [nau_pkg::QUO_W-1:0]   p1_q_reg;
    logic signed [nau_pkg::Y_W-1:0] p1_tanh_reg;

    logic                        out_vld_reg;
    logic [nau_pkg::MODE_W-1:0]  out_mode_reg;
    logic signed [nau_pkg::SAMPLE_W-1:0] out_act_reg;

    logic [nau_pkg::DEN_W-1:0]   den_c;
    logic [nau_pkg::NUM_W-1:0]   num_c;
    logic [nau_pkg::DEN_W-1:0]   w_c;
    logic [34:0]                 gp_c;
    logic [16:0]                 tr_sum_c;
    logic [11:0]                 tr_c;
    logic signed [nau_pkg::Y_W-1:0] tanh_c;
    logic [34:0]                 gp_sum_c;
    logic [16:0]                 yg_c;
    logic signed [nau_pkg::Y_W-1:0] gelu_c;
    logic signed [nau_pkg::Y_W-1:0] y_c;
    logic signed [32:0]          y_ext_c;
    logic signed [32:0]          sat_c;

    // Advance when the output register is free or being taken
    assign adv         = !out_vld_reg || out_ch.ready;
    assign in_ch.ready = adv;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= nau_pkg::MODE_RELU;
            slope_reg <= nau_pkg::SLOPE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                nau_pkg::CFG_MODE:  mode_reg  <= cfg_data[nau_pkg::MODE_W-1:0];
                nau_pkg::CFG_SLOPE: slope_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    nau_arg u_arg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (in_ch.valid),
        .in_x     (in_ch.sample),
        .in_mode  (mode_reg),
        .in_slope (slope_reg),
        .out_vld  (arg_vld),
        .out_t    (arg_t),
        .out_side (arg_side)
    );

    nau_exp u_exp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (arg_vld),
        .in_t     (arg_t),
        .in_side  (arg_side),
        .out_vld  (exp_vld),
        .out_e    (exp_e),
        .out_side (exp_side)
    );

    // Build dividend and divisor for sigmoid, or for tanh (also used by GELU)
    assign den_c = 18'd65536 + {1'b0, exp_e};

    always_comb
    begin
        if (exp_side.mode == nau_pkg::MODE_SIGMOID)
        begin
            if (!exp_side.x[15])
                num_c = 34'd134217728 + {17'b0, den_c[17:1]};
            else
                num_c = {6'b0, exp_e, 11'b0} + {17'b0, den_c[17:1]};
        end
        else
        begin
            num_c = {1'b0, 17'd65536 - exp_e, 16'b0} + {17'b0, den_c[17:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            prep_vld_reg <= exp_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prep_num_reg  <= num_c;
            prep_den_reg  <= den_c;
            prep_side_reg <= exp_side;
        end
    end

    nau_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (prep_vld_reg),
        .in_num   (prep_num_reg),
        .in_den   (prep_den_reg),
        .in_side  (prep_side_reg),
        .out_vld  (div_vld),
        .out_q    (div_q),
        .out_side (div_side)
    );

    // GELU weight product and tanh rescale
    assign w_c      = div_side.x[15] ? (18'd65536 - {1'b0, div_q})
                                     : (18'd65536 + {1'b0, div_q});
    assign gp_c     = div_side.mag * w_c;
    assign tr_sum_c = div_q + 17'd16;
    assign tr_c     = tr_sum_c[16:5];
    assign tanh_c   = div_side.x[15] ? (18'sd0 - $signed({6'b0, tr_c}))
                                     : $signed({6'b0, tr_c});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_vld_reg <= div_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_side_reg <= div_side;
            p1_gp_reg   <= gp_c;
            p1_q_reg    <= div_q;
            p1_tanh_reg <= tanh_c;
        end
    end

    // Select by mode, then saturate
    assign gp_sum_c = p1_gp_reg + 35'd65536;
    assign yg_c     = gp_sum_c[33:17];
    assign gelu_c   = p1_side_reg.x[15] ? (18'sd0 - $signed({1'b0, yg_c}))
                                        : $signed({1'b0, yg_c});

    always_comb
    begin
        case (p1_side_reg.mode)
            nau_pkg::MODE_SIGMOID: y_c = $signed({1'b0, p1_q_reg});
            nau_pkg::MODE_TANH:    y_c = p1_tanh_reg;
            nau_pkg::MODE_GELU:    y_c = gelu_c;
            default:               y_c = p1_side_reg.simple_y;
        endcase
    end

    assign y_ext_c = {{15{y_c[17]}}, y_c};
    assign sat_c   = (y_ext_c > SAT_HI) ? SAT_HI :
                     (y_ext_c < SAT_LO) ? SAT_LO : y_ext_c;

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_act_reg  <= sat_c[nau_pkg::SAMPLE_W-1:0];
            out_mode_reg <= p1_side_reg.mode;
        end
    end

    assign out_ch.valid     = out_vld_reg;
    assign out_ch.activated = out_act_reg;

    // Relu never yields a negative result
    a_relu_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && (out_mode_reg == nau_pkg::MODE_RELU) |-> !out_act_reg[15])
        else $error("relu result negative");

    // Sigmoid stays within [0, 1.0]
    a_sigmoid_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && (out_mode_reg == nau_pkg::MODE_SIGMOID)
        |-> !out_act_reg[15] && (out_act_reg <= 16'sd2048))
        else $error("sigmoid result out of range");

    // Tanh stays within [-1.0, 1.0]
    a_tanh_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && (out_mode_reg == nau_pkg::MODE_TANH)
        |-> (out_act_reg <= 16'sd2048) && (out_act_reg >= -16'sd2048))
        else $error("tanh result out of range");

endmodule

// ===== sim/neural_activation_unit_tb.sv =====
// Self-checking testbench for the neural activation unit: directed and random samples.
module neural_activation_unit_tb;

    localparam int LIMIT = 400000;
    localparam logic [nau_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [nau_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [nau_pkg::CFG_DATA_W-1:0] cfg_data;

    nau_sample_if in_ch ();
    nau_result_if out_ch ();

    neural_activation_unit #(.DATA_WIDTH(16)) uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source),
        .cfg_we(cfg_we),
        .cfg_idx(cfg_idx),
        .cfg_data(cfg_data)
    );

    // predictor copy of the registers
    logic [nau_pkg::MODE_W-1:0] cur_mode;
    logic [nau_pkg::SLOPE_W-1:0] cur_slope;

    logic signed [nau_pkg::SAMPLE_W-1:0] pending_samples[$];
    logic signed [nau_pkg::SAMPLE_W-1:0] expected_results[$];
    int errors = 0;
    int cycles = 0;
    int send_gap;
    int recv_gap;

    localparam logic [16:0] EXP2_TAB[16] = '{65536, 62757, 60097, 57549, 55109, 52773,
        50535, 48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219};

    function automatic longint round_shift(longint v, int n);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (longint'(1) << (n - 1))) >>> n;
        return (v < 0) ? -m : m;
    endfunction

    // exp(-t) for t >= 0 in Q.16
    function automatic longint exp_neg_q16(longint t);
        longint u, n, k, r, a, p, m;
        u = (t * 94548 + 32768) >>> 16;
        n = u >>> 16;
        k = (u >>> 12) & 15;
        r = u & 'hFFF;
        if (n >= 18)
            return 0;
        a = (r * 45426 + 32768) >>> 16;
        p = 65536 - a + ((a * a + 65536) >>> 17);
        m = (longint'(EXP2_TAB[k]) * p + 32768) >>> 16;
        if (n == 0)
            return m;
        return (m + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint tanh_q16(longint z);
        longint mag, e, den, th;
        mag = (z < 0) ? -z : z;
        if (mag > (longint'(8) << 16))
            mag = longint'(8) << 16;
        e = exp_neg_q16(mag * 2);
        den = 65536 + e;
        th = (((65536 - e) << 16) + den / 2) / den;
        return (z < 0) ? -th : th;
    endfunction

    function automatic logic signed [nau_pkg::SAMPLE_W-1:0] activate(
        logic signed [nau_pkg::SAMPLE_W-1:0] s);
        longint x, y, a, e, den, c3, inner, cm, th;
        x = s;
        a = (x < 0) ? -x : x;
        case (cur_mode)
            nau_pkg::MODE_RELU: y = (x < 0) ? 0 : x;
            nau_pkg::MODE_LEAKY: y = (x < 0) ? round_shift(x * longint'(cur_slope), 16) : x;
            nau_pkg::MODE_SIGMOID:
            begin
                e = exp_neg_q16(a << 5);
                den = 65536 + e;
                y = (x >= 0) ? ((longint'(1) << 27) + den / 2) / den
                             : ((e << 11) + den / 2) / den;
            end
            nau_pkg::MODE_TANH: y = round_shift(tanh_q16(x * 32), 5);
            nau_pkg::MODE_GELU:
            begin
                c3 = (a * a * a + 65536) >>> 17;
                inner = (a << 5) + ((c3 * 750193 + 8388608) >>> 24);
                cm = (inner * 13386282 + 8388608) >>> 24;
                th = tanh_q16(cm);
                if (x < 0)
                    th = -th;
                y = round_shift(x * (65536 + th), 17);
            end
            default: y = x;
        endcase
        if (y > 32767)
            y = 32767;
        if (y < -32768)
            y = -32768;
        return y[nau_pkg::SAMPLE_W-1:0];
    endfunction

    task automatic report_mismatch(string what, logic signed [nau_pkg::SAMPLE_W-1:0] got,
                                   logic signed [nau_pkg::SAMPLE_W-1:0] want);
        $display("mismatch %s: got %0d want %0d (mode %0d)", what, got, want, cur_mode);
        errors++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // feed samples; prediction made on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.sample <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                expected_results.push_back(activate(in_ch.sample));
            if (in_ch.valid && !in_ch.ready)
            begin
            end
            else if (send_gap > 0)
            begin
                in_ch.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_samples.size() > 0)
            begin
                in_ch.valid <= 1'b1;
                in_ch.sample <= pending_samples.pop_front();
                send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // check results, stall the receiver at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected beat", out_ch.activated, '0);
                else if (out_ch.activated !== expected_results[0])
                    report_mismatch("activated", out_ch.activated, expected_results.pop_front());
                else
                    void'(expected_results.pop_front());
            end
            if (recv_gap > 0)
            begin
                out_ch.ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (out_ch.valid && out_ch.ready)
                    recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [nau_pkg::CFG_IDX_W-1:0] idx,
                             logic [nau_pkg::CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == nau_pkg::CFG_MODE)
            cur_mode = val[nau_pkg::MODE_W-1:0];
        else if (idx == nau_pkg::CFG_SLOPE)
            cur_slope = val;
    endtask

    // wait until the pipeline has drained
    task automatic drain();
        while (pending_samples.size() > 0 || in_ch.valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic signed [nau_pkg::SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 65535));
            1: return $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
            2: return $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
            default: return ($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000)
                            ^ 16'($urandom_range(0, 31));
        endcase
    endfunction

    initial
    begin
        logic signed [nau_pkg::SAMPLE_W-1:0] edge_vals[12];
        logic [nau_pkg::CFG_DATA_W-1:0] slopes[4];
        edge_vals = '{16'sh0000, 16'sh0001, 16'shFFFF, 16'sh7FFF, 16'sh8000, 16'sh0800,
                      16'shF800, 16'sh1000, 16'shE000, 16'sh4000, 16'shC000, 16'sh5555};
        slopes = '{16'd0, 16'd65535, 16'd32768, 16'd12345};
        cur_mode = nau_pkg::MODE_RELU;
        cur_slope = nau_pkg::SLOPE_RESET;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, then each mode over the field extremes
        for (int m = 0; m < 8; m++)
        begin
            if (m > 0)
                write_reg(nau_pkg::CFG_MODE, 16'(m));
            if (m == nau_pkg::MODE_LEAKY)
                write_reg(nau_pkg::CFG_SLOPE, 16'd0);
            for (int i = 0; i < 12; i++)
                pending_samples.push_back(edge_vals[i]);
            drain();
        end
        // ignored index, then leaky with the slope maximum
        write_reg(CFG_UNUSED, 16'hFFFF);
        write_reg(nau_pkg::CFG_MODE, 16'(nau_pkg::MODE_LEAKY));
        write_reg(nau_pkg::CFG_SLOPE, 16'hFFFF);
        for (int i = 0; i < 12; i++)
            pending_samples.push_back(edge_vals[i]);
        drain();

        // random phases across modes and slopes
        for (int ph = 0; ph < 9; ph++)
        begin
            write_reg(nau_pkg::CFG_MODE, 16'((ph < 8) ? ph : $urandom_range(0, 7)));
            write_reg(nau_pkg::CFG_SLOPE,
                      (ph < 4) ? slopes[ph] : 16'($urandom_range(0, 65535)));
            for (int i = 0; i < 38; i++)
                pending_samples.push_back(rand_sample());
            drain();
        end

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/nau_pkg.sv
rtl/core/nau_sample_if.sv
rtl/core/nau_result_if.sv
rtl/core/nau_arg.sv
rtl/core/nau_exp.sv
rtl/core/nau_div.sv
rtl/core/neural_activation_unit.sv
sim/neural_activation_unit_tb.sv
